/* hdl/null_collision_channel_select_top_macros.svh */
// Assertion macros shared by the null-collision channel select RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef NULL_COLLISION_CHANNEL_SELECT_TOP_MACROS_SVH
`define NULL_COLLISION_CHANNEL_SELECT_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ncs_pkg.sv */
// Shared types and constants for the null-collision channel select block.
// No dependencies; imported by the front end, the back end and the top.
`timescale 1ns / 1ps

package ncs_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int GRID_POINTS_DEF  = 256;
  localparam int QUEUE_DEPTH      = 2;
  localparam logic [23:0] SIGMA_LIMIT = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    K_GRID = 2'd0,
    K_XS   = 2'd1,
    K_THR  = 2'd2,
    K_TEST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_POINT_COUNT   = 2'd1,
    REG_ENERGY_SCALE  = 2'd2,
    REG_COLL_BOUND    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [8:0]  point_count;
    logic [31:0] energy_scale;
    logic [59:0] coll_bound;
  } cfg_t;

  // Classified transaction as it sits in the queue between front and back.
  typedef struct packed {
    kind_t       op;
    logic        addr_ok;
    logic [7:0]  point_index;
    logic [2:0]  channel_index;
    logic [31:0] value;
    logic [31:0] d0;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] draw;
  } item_t;

endpackage

/* hdl/ncs_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ncs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ncs_front.sv */
// Front end: classifies incoming transactions and holds them in a short queue.
// Depends on ncs_pkg.
`timescale 1ns / 1ps

module ncs_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int GRID_POINTS  = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    kind,
  input  logic [7:0]    point_index,
  input  logic [2:0]    channel_index,
  input  logic [31:0]   table_value,
  input  logic [31:0]   incident_vx,
  input  logic [31:0]   incident_vy,
  input  logic [31:0]   incident_vz,
  input  logic [31:0]   partner_vx,
  input  logic [31:0]   partner_vy,
  input  logic [31:0]   partner_vz,
  input  logic [31:0]   uniform_draw,
  output logic          item_valid,
  output ncs_pkg::item_t item,
  input  logic          item_pop
);
  import ncs_pkg::*;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  item_t       slots [QUEUE_DEPTH];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  item_t       cls;
  logic        pt_ok;
  logic        ch_ok;
  logic        push_ok;

  assign pt_ok = 32'(point_index) < GRID_POINTS;
  assign ch_ok = 32'(channel_index) < MAX_CHANNELS;

  always_comb begin
    cls.op            = kind_t'(kind);
    cls.point_index   = point_index;
    cls.channel_index = channel_index;
    cls.value         = table_value;
    cls.d0            = abs_diff(incident_vx, partner_vx);
    cls.d1            = abs_diff(incident_vy, partner_vy);
    cls.d2            = abs_diff(incident_vz, partner_vz);
    cls.draw          = uniform_draw;
    unique case (kind_t'(kind))
      K_GRID: cls.addr_ok = pt_ok;
      K_XS: begin
        cls.addr_ok = pt_ok && ch_ok;
        // clip oversized cross sections to 24 bits
        if (table_value > 32'(SIGMA_LIMIT)) begin
          cls.value = 32'(SIGMA_LIMIT);
        end
      end
      K_THR:   cls.addr_ok = ch_ok;
      default: cls.addr_ok = 1'b0;
    endcase
  end

  assign full       = count == 2'(QUEUE_DEPTH);
  assign item_valid = count != 2'd0;
  assign item       = slots[rptr];
  assign push_ok    = push && !full;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_ok) begin
        wptr <= ~wptr;
      end
      if (item_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push_ok) - 2'(item_pop);
    end
  end

endmodule

/* hdl/ncs_back.sv */
// Back end: applies table loads and runs the test sequence on one shared
// multiplier, a serial root, a grid search and a serial divide per interpolated channel.
// Depends on ncs_pkg, ncs_ram and the assertion macro header.
`timescale 1ns / 1ps

`include "null_collision_channel_select_top_macros.svh"

module ncs_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int GRID_POINTS  = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  ncs_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  ncs_pkg::item_t item,
  output logic           item_pop,
  output logic           empty,
  input  logic           pop,
  output logic           collided,
  output logic [2:0]     channel,
  output logic [31:0]    relative_energy,
  output logic [31:0]    relative_speed,
  output logic [31:0]    excess_energy
);
  import ncs_pkg::*;

  localparam int IDX_W = $clog2(GRID_POINTS);
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XS_D  = MAX_CHANNELS * GRID_POINTS;
  localparam int XS_AW = $clog2(XS_D);

  typedef enum logic [27:0] {
    S_IDLE       = 28'h0000001,
    S_SQ_MUL     = 28'h0000002,
    S_SQ_ADD     = 28'h0000004,
    S_EN_MUL     = 28'h0000008,
    S_EN_ADD     = 28'h0000010,
    S_ROOT       = 28'h0000020,
    S_TH_MUL0    = 28'h0000040,
    S_TH_ADD0    = 28'h0000080,
    S_TH_MUL1    = 28'h0000100,
    S_TH_ADD1    = 28'h0000200,
    S_GRID_FIRST = 28'h0000400,
    S_GRID_LAST  = 28'h0000800,
    S_GRID_CHK   = 28'h0001000,
    S_SRCH       = 28'h0002000,
    S_SRCH_CMP   = 28'h0004000,
    S_GLO        = 28'h0008000,
    S_GHI        = 28'h0010000,
    S_GWAIT      = 28'h0020000,
    S_CH         = 28'h0040000,
    S_SLO        = 28'h0080000,
    S_SHI        = 28'h0100000,
    S_LSEL       = 28'h0200000,
    S_DINIT      = 28'h0400000,
    S_DIV        = 28'h0800000,
    S_SIG        = 28'h1000000,
    S_SV         = 28'h2000000,
    S_SUM        = 28'h4000000,
    S_DONE       = 28'h8000000
  } state_t;

  state_t state;

  // test operands and intermediate values
  logic [31:0] d0, d1, d2, draw;
  logic [65:0] s2;
  logic [97:0] acc;
  logic [63:0] mul_q;
  logic [31:0] mul_a, mul_b;
  logic [4:0]  cnt;
  logic [31:0] energy, speed;
  logic [63:0] rv;
  logic [33:0] rrem;
  logic [31:0] root;
  logic [60:0] thr, sum, sum_n;
  logic [IDX_W-1:0] ilo, ihi, mid, n_m1;
  logic [IDX_W:0]   mid_w;
  logic [31:0] glo, ghi;
  logic [CH_W:0] k, m_c;
  logic [23:0] slo, shi, sig, dq, ldiff;
  logic [31:0] drem, e_off, den;
  logic hit;
  logic [2:0]  chosen;
  logic [31:0] excess;
  logic [31:0] thr_tab [MAX_CHANNELS];
  logic out_valid;

  // memories
  logic             grid_we, xs_we;
  logic [IDX_W-1:0] grid_waddr, grid_raddr;
  logic [31:0]      grid_q;
  logic [XS_AW-1:0] xs_waddr, xs_raddr;
  logic [23:0]      xs_q;

  logic [31:0] pc32, n32, cc32;
  logic [35:0] root_t, root_trial;
  logic [32:0] div_t;
  logic        root_bit, div_bit;
  logic [31:0] energy_c;

  ncs_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(item.value),
    .raddr(grid_raddr), .rdata(grid_q)
  );

  ncs_ram #(.WIDTH(24), .DEPTH(XS_D)) u_xs (
    .clk(clk), .we(xs_we), .waddr(xs_waddr), .wdata(item.value[23:0]),
    .raddr(xs_raddr), .rdata(xs_q)
  );

  assign item_pop   = (state == S_IDLE) && item_valid;
  assign grid_we    = item_pop && item.op == K_GRID && item.addr_ok;
  assign xs_we      = item_pop && item.op == K_XS && item.addr_ok;
  assign grid_waddr = IDX_W'(32'(item.point_index));
  assign xs_waddr   = XS_AW'(32'(item.channel_index) * 32'(GRID_POINTS)
                             + 32'(item.point_index));

  // clamped counts
  assign pc32  = 32'(cfg.point_count);
  assign n32   = (pc32 < 32'd2) ? 32'd2 :
                 ((pc32 > 32'(GRID_POINTS)) ? 32'(GRID_POINTS) : pc32);
  assign n_m1  = IDX_W'(n32 - 32'd1);
  assign cc32  = 32'(cfg.channel_count);
  assign m_c   = (CH_W + 1)'((cc32 > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : cc32);
  assign mid_w = ({1'b0, ilo} + {1'b0, ihi}) >> 1;

  always_comb begin
    grid_raddr = '0;
    unique case (state)
      S_GRID_LAST: grid_raddr = n_m1;
      S_SRCH:      grid_raddr = mid_w[IDX_W-1:0];
      S_GLO:       grid_raddr = ilo;
      S_GHI:       grid_raddr = ihi;
      default:     grid_raddr = '0;
    endcase
  end

  always_comb begin
    if (state == S_SLO) begin
      xs_raddr = XS_AW'(32'(k) * 32'(GRID_POINTS) + 32'(ihi));
    end else begin
      xs_raddr = XS_AW'(32'(k) * 32'(GRID_POINTS) + 32'(ilo));
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_MUL: begin
        unique case (cnt[1:0])
          2'd0:    mul_a = d0;
          2'd1:    mul_a = d1;
          default: mul_a = d2;
        endcase
        mul_b = mul_a;
      end
      S_EN_MUL: begin
        unique case (cnt[1:0])
          2'd0:    mul_a = s2[31:0];
          2'd1:    mul_a = s2[63:32];
          default: mul_a = {30'd0, s2[65:64]};
        endcase
        mul_b = cfg.energy_scale;
      end
      S_TH_MUL0: begin
        mul_a = draw;
        mul_b = cfg.coll_bound[31:0];
      end
      S_TH_MUL1: begin
        mul_a = draw;
        mul_b = {4'd0, cfg.coll_bound[59:32]};
      end
      S_LSEL: begin
        mul_a = {8'd0, ldiff};
        mul_b = e_off;
      end
      S_SV: begin
        mul_a = {8'd0, sig};
        mul_b = speed;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ldiff      = (shi >= slo) ? (shi - slo) : (slo - shi);
  assign e_off      = energy - glo;
  assign den        = ghi - glo;
  assign root_t     = {rrem, rv[63:62]};
  assign root_trial = {2'b00, root, 2'b01};
  assign root_bit   = root_t >= root_trial;
  assign div_t      = {drem, dq[23]};
  assign div_bit    = div_t >= {1'b0, den};
  assign energy_c   = (acc[97:80] != 18'd0) ? 32'hFFFF_FFFF : acc[79:48];
  assign sum_n      = sum + 61'(mul_q);

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (item_pop && item.op == K_THR && item.addr_ok) begin
      thr_tab[CH_W'(32'(item.channel_index))] <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid && item.op == K_TEST) begin
            d0    <= item.d0;
            d1    <= item.d1;
            d2    <= item.d2;
            draw  <= item.draw;
            s2    <= '0;
            cnt   <= '0;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ADD;
        S_SQ_ADD: begin
          s2 <= s2 + 66'(mul_q);
          if (cnt == 5'd2) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_EN_MUL;
          end else begin
            cnt   <= cnt + 5'd1;
            state <= S_SQ_MUL;
          end
        end
        S_EN_MUL: state <= S_EN_ADD;
        S_EN_ADD: begin
          unique case (cnt[1:0])
            2'd0:    acc <= acc + 98'(mul_q);
            2'd1:    acc <= acc + {2'b00, mul_q, 32'd0};
            default: acc <= acc + {mul_q[33:0], 64'd0};
          endcase
          if (cnt == 5'd2) begin
            cnt   <= '0;
            rv    <= s2[63:0];
            rrem  <= '0;
            root  <= '0;
            state <= S_ROOT;
          end else begin
            cnt   <= cnt + 5'd1;
            state <= S_EN_MUL;
          end
        end
        S_ROOT: begin
          // one result bit per cycle, two radicand bits in
          energy <= energy_c;
          rv     <= {rv[61:0], 2'b00};
          rrem   <= root_bit ? 34'(root_t - root_trial) : 34'(root_t);
          root   <= {root[30:0], root_bit};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            speed <= (s2[65:64] != 2'd0) ? 32'hFFFF_FFFF : {root[30:0], root_bit};
            state <= S_TH_MUL0;
          end
        end
        S_TH_MUL0: state <= S_TH_ADD0;
        S_TH_ADD0: begin
          thr   <= 61'(mul_q[63:32]) + 61'(mul_q[31:0] != 32'd0);
          state <= S_TH_MUL1;
        end
        S_TH_MUL1: state <= S_TH_ADD1;
        S_TH_ADD1: begin
          thr   <= thr + 61'(mul_q);
          state <= S_GRID_FIRST;
        end
        S_GRID_FIRST: state <= S_GRID_LAST;
        S_GRID_LAST: begin
          if (energy <= grid_q) begin
            ilo   <= '0;
            ihi   <= '0;
            state <= S_GLO;
          end else begin
            state <= S_GRID_CHK;
          end
        end
        S_GRID_CHK: begin
          if (energy >= grid_q) begin
            ilo <= n_m1;
            ihi <= n_m1;
            state <= S_GLO;
          end else begin
            ilo <= '0;
            ihi <= n_m1;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if ({1'b0, ilo} + 1'b1 == {1'b0, ihi}) begin
            state <= S_GLO;
          end else begin
            mid   <= mid_w[IDX_W-1:0];
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (grid_q < energy) begin
            ilo <= mid;
          end else if (grid_q > energy) begin
            ihi <= mid;
          end else begin
            ilo <= mid;
            ihi <= mid + 1'b1;
          end
          state <= S_SRCH;
        end
        S_GLO: state <= S_GHI;
        S_GHI: begin
          glo   <= grid_q;
          state <= S_GWAIT;
        end
        S_GWAIT: begin
          ghi   <= grid_q;
          k     <= '0;
          sum   <= '0;
          state <= S_CH;
        end
        S_CH: begin
          if (k == m_c) begin
            hit    <= 1'b0;
            chosen <= '0;
            excess <= '0;
            state  <= S_DONE;
          end else if (energy > thr_tab[k[CH_W-1:0]]) begin
            state <= S_SLO;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SLO: begin
          slo   <= xs_q;
          state <= S_SHI;
        end
        S_SHI: begin
          shi   <= xs_q;
          state <= S_LSEL;
        end
        S_LSEL: begin
          // clamp at the interval ends, otherwise divide
          if (ghi <= glo || energy <= glo) begin
            sig   <= slo;
            state <= S_SV;
          end else if (energy >= ghi) begin
            sig   <= shi;
            state <= S_SV;
          end else begin
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          drem  <= mul_q[55:24];
          dq    <= mul_q[23:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= div_bit ? 32'(div_t - {1'b0, den}) : div_t[31:0];
          dq   <= {dq[22:0], div_bit};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            state <= S_SIG;
          end
        end
        S_SIG: begin
          sig   <= (shi >= slo) ? slo + dq : slo - dq;
          state <= S_SV;
        end
        S_SV: state <= S_SUM;
        S_SUM: begin
          sum <= sum_n;
          if (thr <= sum_n) begin
            hit    <= 1'b1;
            chosen <= 3'(k);
            excess <= energy - thr_tab[k[CH_W-1:0]];
            state  <= S_DONE;
          end else begin
            k     <= k + 1'b1;
            state <= S_CH;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            collided        <= hit;
            channel         <= chosen;
            relative_energy <= energy;
            relative_speed  <= speed;
            excess_energy   <= excess;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

  `NCS_ASSERT_NEXT(a_root_exit, state == S_ROOT && cnt == 5'd31, state == S_TH_MUL0, "root loop did not finish after 32 steps")
  `NCS_ASSERT_NEXT(a_done_load, state == S_DONE && !out_valid, out_valid && state == S_IDLE, "result not loaded into free output slot")
  `NCS_ASSERT(a_walk_bound, state != S_CH || k <= m_c, "channel walk ran past the channel count")
  `NCS_ASSERT_NEXT(a_load_stay, item_pop && item.op != K_TEST, state == S_IDLE, "table load left the idle state")

endmodule

/* hdl/null_collision_channel_select_top.sv */
// Loads pass through the queue and are applied when popped; a test item runs a
// 32-step root, an up to 8-step grid search, then walks the channels with a
// 24-step divide per interpolated channel. One test runs at a time.
// A result slot and a two-entry input queue decouple both sides.
// Synchronous reset restores the register defaults; tables stay undefined.
// Depends on ncs_pkg, ncs_front, ncs_back.
`timescale 1ns / 1ps

module null_collision_channel_select_top #(
  parameter int MAX_CHANNELS = ncs_pkg::MAX_CHANNELS_DEF,
  parameter int GRID_POINTS  = ncs_pkg::GRID_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [59:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  point_index,
  input  logic [2:0]  channel_index,
  input  logic [31:0] table_value,
  input  logic [31:0] incident_vx,
  input  logic [31:0] incident_vy,
  input  logic [31:0] incident_vz,
  input  logic [31:0] partner_vx,
  input  logic [31:0] partner_vy,
  input  logic [31:0] partner_vz,
  input  logic [31:0] uniform_draw,
  output logic        empty,
  input  logic        pop,
  output logic        collided,
  output logic [2:0]  channel,
  output logic [31:0] relative_energy,
  output logic [31:0] relative_speed,
  output logic [31:0] excess_energy
);
  import ncs_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= 4'd1;
      cfg.point_count   <= 9'd2;
      cfg.energy_scale  <= 32'd0;
      cfg.coll_bound    <= 60'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[3:0];
        REG_POINT_COUNT:   cfg.point_count   <= cfg_data[8:0];
        REG_ENERGY_SCALE:  cfg.energy_scale  <= cfg_data[31:0];
        REG_COLL_BOUND:    cfg.coll_bound    <= cfg_data;
        default:           cfg.channel_count <= cfg.channel_count;
      endcase
    end
  end

  ncs_front #(.MAX_CHANNELS(MAX_CHANNELS), .GRID_POINTS(GRID_POINTS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .kind(kind), .point_index(point_index), .channel_index(channel_index),
    .table_value(table_value),
    .incident_vx(incident_vx), .incident_vy(incident_vy), .incident_vz(incident_vz),
    .partner_vx(partner_vx), .partner_vy(partner_vy), .partner_vz(partner_vz),
    .uniform_draw(uniform_draw),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  ncs_back #(.MAX_CHANNELS(MAX_CHANNELS), .GRID_POINTS(GRID_POINTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .empty(empty), .pop(pop),
    .collided(collided), .channel(channel), .relative_energy(relative_energy),
    .relative_speed(relative_speed), .excess_energy(excess_energy)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for null_collision_channel_select_top: fills the tables,
// walks a directed table, then runs random phases against a bit-exact predictor.
// Depends on ncs_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import ncs_pkg::*;

  // cross sections are loaded for this many points; larger point counts run
  // only with no channels in use
  localparam int FILL_POINTS = 64;

  typedef struct packed {
    logic        collided;
    logic [2:0]  channel;
    logic [31:0] energy;
    logic [31:0] speed;
    logic [31:0] excess;
  } outcome_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pt;
    logic [2:0]  ch;
    logic [31:0] val;
    logic [31:0] ivx, ivy, ivz;
    logic [31:0] pvx, pvy, pvz;
    logic [31:0] draw;
  } txn_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    idx;
    logic [59:0] data;
    txn_t        txn;
    logic        typed;
    outcome_t    want;
  } row_t;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [59:0] cfg_data;
  logic        push, full, empty, pop;
  logic [1:0]  kind;
  logic [7:0]  point_index;
  logic [2:0]  channel_index;
  logic [31:0] table_value, uniform_draw;
  logic [31:0] incident_vx, incident_vy, incident_vz;
  logic [31:0] partner_vx, partner_vy, partner_vz;
  logic        collided;
  logic [2:0]  channel;
  logic [31:0] relative_energy, relative_speed, excess_energy;

  // shadow copy of tables and registers
  logic [31:0] grid_m [256];
  logic [23:0] xs_m [8][256];
  logic [31:0] thr_m [8];
  logic [3:0]  chan_cnt_m;
  logic [8:0]  pt_cnt_m;
  logic [31:0] escale_m;
  logic [59:0] svmax_m;

  outcome_t pending_q[$];
  row_t     dir_rows[$];
  int       mismatches = 0;
  bit       quiet = 0;

  null_collision_channel_select_top i_dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("null_collision_channel_select_top test failed");
    $finish;
  end

  always @(negedge clk) pop <= quiet || ($urandom_range(99) >= 18);

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [32:0] vdiff(logic [31:0] a, logic [31:0] b);
    longint x, y, d;
    x = longint'($signed(a));
    y = longint'($signed(b));
    d = x - y;
    if (d < 0) d = -d;
    return d[32:0];
  endfunction

  function automatic logic [31:0] interp(logic [31:0] s_lo, logic [31:0] s_hi,
                                         logic [31:0] g_lo, logic [31:0] g_hi,
                                         logic [31:0] e);
    logic [63:0] num, den, q;
    if (g_hi <= g_lo || e <= g_lo) return s_lo;
    if (e >= g_hi) return s_hi;
    num = 64'(e - g_lo);
    den = 64'(g_hi - g_lo);
    if (s_hi >= s_lo) begin
      q = (64'(s_hi - s_lo) * num) / den;
      return s_lo + q[31:0];
    end
    q = (64'(s_lo - s_hi) * num) / den;
    return s_lo - q[31:0];
  endfunction

  function automatic outcome_t predict_collision(txn_t t);
    outcome_t    o;
    logic [32:0] d0, d1, d2;
    logic [65:0] sq;
    logic [97:0] prod;
    logic [91:0] dp;
    logic [63:0] thr, sum;
    logic [31:0] sig;
    int          n, m, ilo, ihi, mid;
    o = '0;
    d0 = vdiff(t.ivx, t.pvx);
    d1 = vdiff(t.ivy, t.pvy);
    d2 = vdiff(t.ivz, t.pvz);
    sq = 66'(d0) * 66'(d0) + 66'(d1) * 66'(d1) + 66'(d2) * 66'(d2);
    o.speed = (sq[65:64] != 0) ? 32'hFFFF_FFFF : isqrt(sq[63:0]);
    prod = 98'(sq) * 98'(escale_m);
    o.energy = (prod[97:80] != 0) ? 32'hFFFF_FFFF : prod[79:48];

    n = (pt_cnt_m < 2) ? 2 : int'(pt_cnt_m);
    if (n > 256) n = 256;
    if (o.energy <= grid_m[0]) begin
      ilo = 0;
      ihi = 0;
    end else if (o.energy >= grid_m[n-1]) begin
      ilo = n - 1;
      ihi = n - 1;
    end else begin
      ilo = 0;
      ihi = n - 1;
      while (ilo + 1 != ihi) begin
        mid = (ilo + ihi) >> 1;
        if (grid_m[mid] < o.energy) ilo = mid;
        else if (grid_m[mid] > o.energy) ihi = mid;
        else begin
          ilo = mid;
          ihi = mid + 1;
        end
      end
    end

    // ceil(draw * bound / 2^32)
    dp = 92'(t.draw) * 92'(svmax_m);
    dp = dp + 92'hFFFF_FFFF;
    thr = 64'(dp >> 32);

    m = (chan_cnt_m > 8) ? 8 : int'(chan_cnt_m);
    sum = 0;
    for (int k = 0; k < m; k++) begin
      if (o.energy > thr_m[k]) begin
        sig = interp(32'(xs_m[k][ilo]), 32'(xs_m[k][ihi]), grid_m[ilo], grid_m[ihi],
                     o.energy);
        sum = sum + 64'(sig) * 64'(o.speed);
        if (thr <= sum) begin
          o.collided = 1'b1;
          o.channel = k[2:0];
          o.excess = o.energy - thr_m[k];
          break;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t got, want;
    if (!rst && pop && !empty) begin
      got = '{collided, channel, relative_energy, relative_speed, excess_energy};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %0d %0d %h %h %h", got.collided, got.channel,
                   got.energy, got.speed, got.excess);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %0d %0d %h %h %h got %0d %0d %h %h %h",
                     want.collided, want.channel, want.energy, want.speed, want.excess,
                     got.collided, got.channel, got.energy, got.speed, got.excess);
        end
      end
    end
  end

  // call at a falling edge; returns at a falling edge with push still high
  task automatic send_txn(txn_t t, logic typed, outcome_t want);
    while (!quiet && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(negedge clk);
    end
    kind <= t.kind;
    point_index <= t.pt;
    channel_index <= t.ch;
    table_value <= t.val;
    incident_vx <= t.ivx;
    incident_vy <= t.ivy;
    incident_vz <= t.ivz;
    partner_vx <= t.pvx;
    partner_vy <= t.pvy;
    partner_vz <= t.pvz;
    uniform_draw <= t.draw;
    push <= 1'b1;
    do @(posedge clk); while (full);
    case (t.kind)
      K_GRID: grid_m[t.pt] = t.val;
      K_XS:   xs_m[t.ch][t.pt] = (t.val > 32'hFF_FFFF) ? SIGMA_LIMIT : t.val[23:0];
      K_THR:  thr_m[t.ch] = t.val;
      K_TEST: pending_q.insert(pending_q.size(), typed ? want : predict_collision(t));
    endcase
    @(negedge clk);
  endtask

  // drain: hold off until every result is back, then let loads retire
  task automatic settle();
    push <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [59:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: chan_cnt_m = d[3:0];
      REG_POINT_COUNT:   pt_cnt_m = d[8:0];
      REG_ENERGY_SCALE:  escale_m = d[31:0];
      REG_COLL_BOUND:    svmax_m = d;
    endcase
  endtask

  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic txn_t mk_load(kind_t k, logic [7:0] pt, logic [2:0] ch,
                                   logic [31:0] val);
    txn_t t;
    t = '0;
    t.kind = k;
    t.pt = pt;
    t.ch = ch;
    t.val = val;
    return t;
  endfunction

  function automatic txn_t mk_test(logic [31:0] ivx, ivy, ivz, pvx, pvy, pvz, draw);
    txn_t t;
    t = '0;
    t.kind = K_TEST;
    t.ivx = ivx;
    t.ivy = ivy;
    t.ivz = ivz;
    t.pvx = pvx;
    t.pvy = pvy;
    t.pvz = pvz;
    t.draw = draw;
    return t;
  endfunction

  function automatic row_t txn_row(txn_t t);
    row_t r;
    r = '0;
    r.txn = t;
    return r;
  endfunction

  // reset settings give zero energy, so no collision: only the speed varies
  function automatic row_t quiet_row(txn_t t, logic [31:0] speed);
    row_t r;
    r = txn_row(t);
    r.typed = 1'b1;
    r.want = '{1'b0, 3'd0, 32'd0, speed, 32'd0};
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_reg_t idx, logic [59:0] d);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic logic [31:0] rand_grid(int pt);
    if ($urandom_range(9) == 0) return $urandom;
    return (pt << 17) + $urandom_range(16'hFFFF);
  endfunction

  function automatic logic [31:0] rand_sigma();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(24'hFF_FFFF);
  endfunction

  function automatic logic [31:0] rand_thr();
    if ($urandom_range(19) == 0) return $urandom;
    return $urandom_range(32'h200_0000);
  endfunction

  function automatic txn_t rand_load();
    txn_t  t;
    kind_t k;
    k = kind_t'($urandom_range(2));
    t = mk_load(k, 8'($urandom), 3'($urandom), 32'd0);
    case (k)
      K_GRID:  t.val = rand_grid(int'(t.pt));
      K_XS:    t.val = rand_sigma();
      default: t.val = rand_thr();
    endcase
    t.ivx = $urandom;
    t.pvz = $urandom;
    t.draw = $urandom;
    return t;
  endfunction

  // mostly a small relative velocity so energies fall on the grid
  function automatic txn_t rand_test();
    txn_t        t;
    int          k;
    logic [31:0] dx, dy, dz;
    t = mk_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    t.pt = 8'($urandom);
    t.ch = 3'($urandom);
    t.val = $urandom;
    if ($urandom_range(99) >= 15) begin
      k = $urandom_range(20);
      dx = ($urandom & ((32'd2 << k) - 1)) - (32'd1 << k);
      dy = ($urandom & ((32'd2 << k) - 1)) - (32'd1 << k);
      dz = ($urandom & ((32'd2 << k) - 1)) - (32'd1 << k);
      t.ivx = t.pvx + dx;
      t.ivy = t.pvy + dy;
      t.ivz = t.pvz + dz;
    end
    return t;
  endfunction

  initial begin
    int          cc_pick [6] = '{8, 1, 0, 15, 3, 8};
    int          pc_pick [6] = '{FILL_POINTS, 2, 511, 0, 40, 1};
    logic [31:0] sc;
    logic [59:0] sv;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    kind = '0;
    point_index = '0;
    channel_index = '0;
    table_value = '0;
    incident_vx = '0;
    incident_vy = '0;
    incident_vz = '0;
    partner_vx = '0;
    partner_vy = '0;
    partner_vz = '0;
    uniform_draw = '0;
    chan_cnt_m = 4'd1;
    pt_cnt_m = 9'd2;
    escale_m = '0;
    svmax_m = 60'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every table entry that a test can reach
    for (int i = 0; i < 256; i++)
      send_txn(mk_load(K_GRID, 8'(i), 3'd0, rand_grid(i)), 0, '0);
    for (int c = 0; c < 8; c++)
      for (int i = 0; i < FILL_POINTS; i++)
        send_txn(mk_load(K_XS, 8'(i), 3'(c), rand_sigma()), 0, '0);
    for (int c = 0; c < 8; c++)
      send_txn(mk_load(K_THR, 8'd0, 3'(c), (c == 0) ? 32'd0 : rand_thr()), 0, '0);

    add_row(quiet_row(mk_test(3, 4, 0, 0, 0, 0, $urandom), 32'd5));
    add_row(quiet_row(mk_test(0, 0, 0, 0, 0, 0, 0), 32'd0));
    add_row(quiet_row(mk_test(-1, -1, -1, 1, 1, 1, '1), 32'd3));
    add_row(quiet_row(mk_test(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0),
                      32'hFFFF_FFFF));
    add_row(quiet_row(mk_test(32'h8000_0000, 32'h8000_0000, 0,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0),
                      32'hFFFF_FFFF));
    add_row(cfg_row(REG_ENERGY_SCALE, 60'hFFFF_FFFF));
    add_row(cfg_row(REG_CHANNEL_COUNT, 60'd8));
    add_row(cfg_row(REG_POINT_COUNT, 60'(FILL_POINTS)));
    add_row(cfg_row(REG_COLL_BOUND, 60'd0));
    add_row(txn_row(mk_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1)));
    add_row(txn_row(mk_test(1024, 0, 0, 0, 0, 0, 32'h8000_0000)));
    add_row(cfg_row(REG_COLL_BOUND, '1));
    add_row(txn_row(mk_test(32'h20_0000, 0, 0, 0, 0, 0, '1)));
    add_row(txn_row(mk_test(32'h20_0000, 0, 0, 0, 0, 0, 0)));
    add_row(txn_row(mk_load(K_XS, 0, 0, 32'hFFFF_FFFF)));
    add_row(txn_row(mk_load(K_GRID, 255, 7, 32'hFFFF_FFFF)));
    add_row(txn_row(mk_load(K_THR, 0, 7, 32'd0)));
    add_row(txn_row(mk_test(0, 0, 0, 0, 0, 0, 0)));
    add_row(cfg_row(REG_CHANNEL_COUNT, 60'd0));
    add_row(txn_row(mk_test(32'h1_0000, 5, -5, 0, 0, 0, 0)));
    add_row(cfg_row(REG_POINT_COUNT, 60'd511));
    add_row(txn_row(mk_test(32'h8_0000, 0, 0, 0, 0, 0, 32'h1000)));
    add_row(cfg_row(REG_CHANNEL_COUNT, 60'd15));
    add_row(cfg_row(REG_POINT_COUNT, 60'd0));
    add_row(txn_row(mk_test(32'h4_0000, 0, 0, 0, 0, 0, 32'h1000)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_txn(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      sc = (p == 1 || p == 5) ? 32'hFFFF_FFFF : (p == 2) ? 32'd0 :
           $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
      sv = (p == 2) ? '1 : (p == 3) ? 60'd0 : (p == 4) ? 60'd1 :
           60'($urandom) << $urandom_range(18, 4);
      write_reg(REG_CHANNEL_COUNT, 60'(cc_pick[p]));
      write_reg(REG_POINT_COUNT, 60'(pc_pick[p]));
      write_reg(REG_ENERGY_SCALE, sc);
      write_reg(REG_COLL_BOUND, sv);
      quiet = (p == 3);
      repeat (78) begin
        if ($urandom_range(99) < 70) send_txn(rand_test(), 0, '0);
        else send_txn(rand_load(), 0, '0);
      end
    end
    quiet = 0;
    push <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("null_collision_channel_select_top test passed");
    end else begin
      $display("null_collision_channel_select_top test failed");
    end
    $finish;
  end

endmodule

/* null_collision_channel_select_top.f */
+incdir+hdl
hdl/ncs_pkg.sv
hdl/ncs_ram.sv
hdl/ncs_front.sv
hdl/ncs_back.sv
hdl/null_collision_channel_select_top.sv
verif/testbench.sv
